FILE: design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants of the point leader clustering block.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int COORD_W     = 16;
    localparam int HITS_W      = 16;
    localparam int RADIUS_W    = 10;
    localparam int STATUS_W    = 3;
    localparam int CINDEX_W    = 6;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int NUM_W       = 2 * COORD_W + 1;
    localparam int MAG_W       = 2 * COORD_W;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] STS_REPORT  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NONE    = 3'd4;

    // configuration port
    localparam int   ADDR_W            = 3;
    localparam int   DATA_W            = 32;
    localparam logic REG_MATCH_RADIUS  = 1'b0;
    localparam logic REG_MIN_COUNT     = 1'b1;
    localparam logic [RADIUS_W-1:0] MATCH_RADIUS_RESET = 10'd10;
    localparam logic [HITS_W-1:0]   MIN_COUNT_RESET    = 16'd5;

    typedef struct packed {
        logic [RADIUS_W-1:0] match_radius;
        logic [HITS_W-1:0]   min_count;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] mean_x;
        logic [COORD_W-1:0] mean_y;
        logic [HITS_W-1:0]  hits;
    } t_entry;

endpackage

FILE: design/plc_regs.sv
// ----------------------------------------------------------------------------
// plc_regs
// APB-style configuration registers: match radius and report threshold.
// ----------------------------------------------------------------------------
module plc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plc_pkg::ADDR_W-1:0]  paddr,
    input  logic [plc_pkg::DATA_W-1:0]  pwdata,
    output logic [plc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output plc_pkg::t_cfg               o_cfg
);
    import plc_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_radius <= MATCH_RADIUS_RESET;
            r_cfg.min_count    <= MIN_COUNT_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_MATCH_RADIUS: r_cfg.match_radius <= pwdata[RADIUS_W-1:0];
                REG_MIN_COUNT:    r_cfg.min_count    <= pwdata[HITS_W-1:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MATCH_RADIUS: prdata = DATA_W'(r_cfg.match_radius);
            REG_MIN_COUNT:    prdata = DATA_W'(r_cfg.min_count);
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: design/plc_table.sv
// ----------------------------------------------------------------------------
// plc_table
// Cluster table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plc_table (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [plc_pkg::IDX_W-1:0]  i_raddr,
    input  logic                       i_we,
    input  logic [plc_pkg::IDX_W-1:0]  i_waddr,
    input  plc_pkg::t_entry            i_wdata,
    output plc_pkg::t_entry            o_rdata
);
    import plc_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/plc_div.sv
// ----------------------------------------------------------------------------
// plc_div
// Serial signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module plc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [plc_pkg::NUM_W-1:0]   i_num,
    input  logic [plc_pkg::HITS_W-1:0]         i_den,
    output logic                               o_done,
    output logic [plc_pkg::COORD_W-1:0]        o_quot
);
    import plc_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [MAG_W-1:0]    r_dvd;
    logic [HITS_W-1:0]   r_rem;
    logic [HITS_W-1:0]   r_den;
    logic                r_neg;
    logic [COORD_W-1:0]  r_quot;

    logic [NUM_W-1:0]    w_mag;
    logic [HITS_W:0]     w_rem_sh;
    logic [HITS_W:0]     w_rem_sub;
    logic                w_ge;
    logic [HITS_W-1:0]   w_rem_nx;
    logic [MAG_W-1:0]    w_dvd_nx;
    logic [COORD_W-1:0]  w_q;
    logic                w_last;

    assign w_mag     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_rem_sh  = {r_rem, r_dvd[MAG_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx  = w_ge ? w_rem_sub[HITS_W-1:0] : w_rem_sh[HITS_W-1:0];
    assign w_dvd_nx  = {r_dvd[MAG_W-2:0], w_ge};
    assign w_q       = w_dvd_nx[COORD_W-1:0];
    assign w_last    = r_busy && (r_cnt == STEP_W'(MAG_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= w_mag[MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_dvd <= w_dvd_nx;
            r_rem <= w_rem_nx;
        end
        if (w_last) begin
            r_quot <= r_neg ? COORD_W'(-w_q) : w_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: design/point_leader_clustering.sv
// ----------------------------------------------------------------------------
// point_leader_clustering
// Leader clustering of 2D points with a running mean and hit count per cluster.
// ----------------------------------------------------------------------------
// Input words (opcode, point_x, point_y) arrive on a valid/ready channel; the
// block takes one word at a time and raises o_in_ready only when idle.
// Result words leave on a valid/ready channel through an output register, so
// a waiting result never blocks the acceptance of the next input word.
// Add: the filled entries are read one a cycle through the table read port,
//   a two-stage distance pipe behind it. A match is merged by a pair of
//   32-step serial dividers that form both new means in parallel.
//   One result word each.
// Flush: each filled entry is read, then tested, and a closing step follows;
//   qualifying entries are reported in table order, the final one with last
//   set, or a single "none reported" word if nothing qualifies.
// Reset clears only the entry count, control state and configuration registers;
// table contents are left undefined and entries beyond the count are never read.
// If the receiver stalls, the block holds in the state that produces the next
// result word until the output register frees up. Configuration (APB-style,
// pready always high) must be written only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module point_leader_clustering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [plc_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [plc_pkg::COORD_W-1:0]   i_point_y,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [plc_pkg::STATUS_W-1:0]         o_status,
    output logic [plc_pkg::CINDEX_W-1:0]         o_cluster_index,
    output logic signed [plc_pkg::COORD_W-1:0]   o_mean_x,
    output logic signed [plc_pkg::COORD_W-1:0]   o_mean_y,
    output logic [plc_pkg::HITS_W-1:0]           o_hit_count,
    output logic                                 o_last,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plc_pkg::ADDR_W-1:0]           paddr,
    input  logic [plc_pkg::DATA_W-1:0]           pwdata,
    output logic [plc_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import plc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_WB   = 4'd4;
    localparam logic [3:0] S_NEW  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCHK = 4'd7;
    localparam logic [3:0] S_FEND = 4'd8;

    // control state
    logic [3:0]           r_state;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     r_issue;     // next entry to read, scan and flush
    logic                 r_s1_v;
    logic                 r_s2_v;
    logic                 r_pend_v;
    logic                 r_out_v;
    logic                 r_div_start;

    // payload
    logic [COORD_W-1:0]   r_px;
    logic [COORD_W-1:0]   r_py;
    logic [2*RADIUS_W-1:0] r_r2;
    logic [IDX_W-1:0]     r_s1_idx;
    logic [IDX_W-1:0]     r_s2_idx;
    t_entry               r_s2_ent;
    logic [SQ_W-1:0]      r_s2_dx2;
    logic [SQ_W-1:0]      r_s2_dy2;
    logic [IDX_W-1:0]     r_m_idx;
    t_entry               r_m_ent;
    logic [HITS_W-1:0]    r_n;
    logic signed [NUM_W-1:0] r_num_x;
    logic signed [NUM_W-1:0] r_num_y;
    logic [IDX_W-1:0]     r_pend_idx;
    t_entry               r_pend_ent;
    logic [STATUS_W-1:0]  r_out_status;
    logic [IDX_W-1:0]     r_out_idx;
    logic [COORD_W-1:0]   r_out_mx;
    logic [COORD_W-1:0]   r_out_my;
    logic [HITS_W-1:0]    r_out_hits;
    logic                 r_out_last;

    // next output word
    logic [STATUS_W-1:0]  n_out_status;
    logic [IDX_W-1:0]     n_out_idx;
    logic [COORD_W-1:0]   n_out_mx;
    logic [COORD_W-1:0]   n_out_my;
    logic [HITS_W-1:0]    n_out_hits;
    logic                 n_out_last;

    t_cfg                 w_cfg;
    t_entry               w_rd;
    t_entry               w_wdata;
    logic [IDX_W-1:0]     w_waddr;
    logic                 w_we;
    logic                 w_re;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_issue;
    logic                 w_hit;
    logic                 w_scan_end;
    logic                 w_room;
    logic                 w_qual;
    logic                 w_wb_fire;
    logic                 w_new_fire;
    logic                 w_fchk_take;
    logic                 w_fend_fire;
    logic                 w_done_x;
    logic                 w_done_y;
    logic [COORD_W-1:0]   w_qx;
    logic [COORD_W-1:0]   w_qy;
    logic signed [COORD_W:0]     w_dx;
    logic signed [COORD_W:0]     w_dy;
    logic signed [SQ_W+1:0]      w_dx_sq;
    logic signed [SQ_W+1:0]      w_dy_sq;
    logic [SQ_W:0]        w_dist;
    logic [HITS_W-1:0]    w_n;
    logic [HITS_W-1:0]    w_nm1;
    logic signed [NUM_W-1:0] w_num_x;
    logic signed [NUM_W-1:0] w_num_y;

    plc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    plc_table u_table (
        .i_clk   (i_clk),
        .i_re    (w_re),
        .i_raddr (r_issue[IDX_W-1:0]),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rd)
    );

    plc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num_x),
        .i_den   (r_n),
        .o_done  (w_done_x),
        .o_quot  (w_qx)
    );

    plc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num_y),
        .i_den   (r_n),
        .o_done  (w_done_y),
        .o_quot  (w_qy)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_v || i_out_ready;

    // distance pipe: stage one squares the offsets of the entry just read,
    // stage two sums and compares against the squared radius
    assign w_dx    = $signed({w_rd.mean_x[COORD_W-1], w_rd.mean_x})
                   - $signed({r_px[COORD_W-1], r_px});
    assign w_dy    = $signed({w_rd.mean_y[COORD_W-1], w_rd.mean_y})
                   - $signed({r_py[COORD_W-1], r_py});
    assign w_dx_sq = w_dx * w_dx;
    assign w_dy_sq = w_dy * w_dy;
    assign w_dist  = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};
    assign w_hit   = (r_state == S_SCAN) && r_s2_v && (w_dist < (SQ_W + 1)'(r_r2));

    // stop reading as soon as a match appears; reads in flight are dropped
    assign w_issue    = (r_state == S_SCAN) && (r_issue < r_used) && !w_hit;
    assign w_scan_end = (r_state == S_SCAN) && !w_hit && (r_issue == r_used)
                     && !r_s1_v && !r_s2_v;
    assign w_re       = w_issue || ((r_state == S_FRD) && (r_issue < r_used));

    // running mean numerator: mean * (n - 1) + p, count saturating
    assign w_n     = (r_m_ent.hits == HITS_MAX) ? HITS_MAX : r_m_ent.hits + 1'b1;
    assign w_nm1   = (r_m_ent.hits == HITS_MAX) ? HITS_MAX - 1'b1 : r_m_ent.hits;
    assign w_num_x = $signed(r_m_ent.mean_x) * $signed({1'b0, w_nm1}) + $signed(r_px);
    assign w_num_y = $signed(r_m_ent.mean_y) * $signed({1'b0, w_nm1}) + $signed(r_py);

    assign w_room      = (r_used < CNT_W'(TABLE_DEPTH));
    assign w_qual      = (w_rd.hits > w_cfg.min_count);
    assign w_wb_fire   = (r_state == S_WB) && w_out_free;
    assign w_new_fire  = (r_state == S_NEW) && w_out_free;
    assign w_fchk_take = (r_state == S_FCHK) && w_qual && (!r_pend_v || w_out_free);
    assign w_fend_fire = (r_state == S_FEND) && w_out_free;
    assign w_out_load  = w_wb_fire || w_new_fire || w_fend_fire
                      || (w_fchk_take && r_pend_v);

    // table writes: merged entry back, or a fresh entry at the fill mark
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_m_idx;
        w_wdata = '{mean_x: w_qx, mean_y: w_qy, hits: r_n};
        if (w_wb_fire) begin
            w_we = 1'b1;
        end else if (w_new_fire && w_room) begin
            w_we    = 1'b1;
            w_waddr = r_used[IDX_W-1:0];
            w_wdata = '{mean_x: r_px, mean_y: r_py, hits: HITS_W'(1)};
        end
    end

    always_comb begin
        n_out_status = STS_NONE;
        n_out_idx    = '0;
        n_out_mx     = '0;
        n_out_my     = '0;
        n_out_hits   = '0;
        n_out_last   = 1'b1;
        case (r_state) inside
            S_WB: begin
                n_out_status = STS_MERGED;
                n_out_idx    = r_m_idx;
                n_out_mx     = w_qx;
                n_out_my     = w_qy;
                n_out_hits   = r_n;
            end
            S_NEW: begin
                if (w_room) begin
                    n_out_status = STS_NEW;
                    n_out_idx    = r_used[IDX_W-1:0];
                    n_out_mx     = r_px;
                    n_out_my     = r_py;
                    n_out_hits   = HITS_W'(1);
                end else begin
                    n_out_status = STS_DROPPED;
                end
            end
            S_FCHK, S_FEND: begin
                // the held report goes out; last only once the walk is over
                if (r_pend_v) begin
                    n_out_status = STS_REPORT;
                    n_out_idx    = r_pend_idx;
                    n_out_mx     = r_pend_ent.mean_x;
                    n_out_my     = r_pend_ent.mean_y;
                    n_out_hits   = r_pend_ent.hits;
                    n_out_last   = (r_state == S_FEND);
                end
            end
            default: begin
                n_out_status = STS_NONE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_issue     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_s1_v      <= w_issue;
            r_s2_v      <= r_s1_v && (r_state == S_SCAN) && !w_hit;
            r_div_start <= (r_state == S_MUL);
            if (w_re) begin
                r_issue <= r_issue + 1'b1;
            end
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_issue  <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= (i_opcode == OP_FLUSH) ? S_FRD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_state <= S_MUL;
                    end else if (w_scan_end) begin
                        r_state <= S_NEW;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (w_done_x) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_wb_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                S_NEW: begin
                    if (w_new_fire) begin
                        if (w_room) begin
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FRD: r_state <= (r_issue < r_used) ? S_FCHK : S_FEND;
                S_FCHK: begin
                    if (!w_qual) begin
                        r_state <= S_FRD;
                    end else if (w_fchk_take) begin
                        r_pend_v <= 1'b1;
                        r_state  <= S_FRD;
                    end
                end
                S_FEND: begin
                    if (w_fend_fire) begin
                        r_used  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_r2 <= w_cfg.match_radius * w_cfg.match_radius;
        end
        r_s1_idx <= r_issue[IDX_W-1:0];
        r_s2_idx <= r_s1_idx;
        r_s2_ent <= w_rd;
        r_s2_dx2 <= w_dx_sq[SQ_W-1:0];
        r_s2_dy2 <= w_dy_sq[SQ_W-1:0];
        if (w_hit) begin
            r_m_idx <= r_s2_idx;
            r_m_ent <= r_s2_ent;
        end
        if (r_state == S_MUL) begin
            r_n     <= w_n;
            r_num_x <= w_num_x;
            r_num_y <= w_num_y;
        end
        if (w_fchk_take) begin
            // r_issue still points past the entry read, so step back one
            r_pend_idx <= IDX_W'(r_issue - 1'b1);
            r_pend_ent <= w_rd;
        end
        if (w_out_load) begin
            r_out_status <= n_out_status;
            r_out_idx    <= n_out_idx;
            r_out_mx     <= n_out_mx;
            r_out_my     <= n_out_my;
            r_out_hits   <= n_out_hits;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_status        = r_out_status;
    assign o_cluster_index = CINDEX_W'(r_out_idx);
    assign o_mean_x        = r_out_mx;
    assign o_mean_y        = r_out_my;
    assign o_hit_count     = r_out_hits;
    assign o_last          = r_out_last;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_add_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_ADD)) |=> (r_state == S_SCAN))
        else $error("add word did not start a table scan");

    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x |-> (w_done_y && (r_state == S_DIV)))
        else $error("dividers out of step or finished outside divide");

    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> (r_issue < r_used))
        else $error("table read beyond filled entries");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_re)
        else $error("table written while a read is in flight");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point leader clustering block.
// ----------------------------------------------------------------------------
// Add and flush words are driven through the input channel. A behavioural
// cluster table inside the bench tracks every accepted word and queues the
// result words it should cause. The checker compares each result word, field
// by field, against the oldest queued one. The configuration is written
// through the APB port only while the block is idle, and it is read back each
// time. Both channels stall in bursts while idling is on, never in the final stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either channel
    localparam int SETTLE      = 4;     // idle cycles before touching the registers
    localparam int TAIL_CYCLES = 160;   // longer than the slowest full-table flush
    localparam int NUM_HUBS    = 6;

    localparam logic [ADDR_W-1:0] RADIUS_ADDR    = {REG_MATCH_RADIUS, 2'b00};
    localparam logic [ADDR_W-1:0] MIN_COUNT_ADDR = {REG_MIN_COUNT, 2'b00};

    // one result word as the block should present it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CINDEX_W-1:0] cindex;
        logic [COORD_W-1:0]  mean_x;
        logic [COORD_W-1:0]  mean_y;
        logic [HITS_W-1:0]   hits;
        logic                last;
    } t_cluster_word;

    // every input is known from time zero
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic                      i_opcode        = OP_ADD;
    logic signed [COORD_W-1:0] i_point_x       = '0;
    logic signed [COORD_W-1:0] i_point_y       = '0;
    logic                      i_out_ready     = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [ADDR_W-1:0]         paddr           = '0;
    logic [DATA_W-1:0]         pwdata          = '0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [STATUS_W-1:0]       o_status;
    logic [CINDEX_W-1:0]       o_cluster_index;
    logic signed [COORD_W-1:0] o_mean_x;
    logic signed [COORD_W-1:0] o_mean_y;
    logic [HITS_W-1:0]         o_hit_count;
    logic                      o_last;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    point_leader_clustering DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_cluster_index (o_cluster_index),
        .o_mean_x        (o_mean_x),
        .o_mean_y        (o_mean_y),
        .o_hit_count     (o_hit_count),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench-side cluster table: its own copy of the registers and entries.
    // ------------------------------------------------------------------------
    logic [RADIUS_W-1:0]       cfg_radius    = MATCH_RADIUS_RESET;
    logic [HITS_W-1:0]         cfg_min_count = MIN_COUNT_RESET;
    logic signed [COORD_W-1:0] tab_mean_x [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tab_mean_y [TABLE_DEPTH];
    logic [HITS_W-1:0]         tab_hits   [TABLE_DEPTH];
    int                        tab_used   = 0;

    t_cluster_word             pending_words [$];   // result words still owed
    int                        mismatches    = 0;
    int                        quiet_cycles  = 0;
    int                        sink_hold     = 0;
    bit                        idling        = 1'b1;

    logic signed [COORD_W-1:0] hub_x [NUM_HUBS];
    logic signed [COORD_W-1:0] hub_y [NUM_HUBS];

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    // Advance the table by one accepted word and queue the words it causes.
    task automatic cluster_predict(input logic op, input logic signed [COORD_W-1:0] px,
                                   input logic signed [COORD_W-1:0] py);
        longint        dx, dy, r2, n;
        int            k, hit_k, last_k;
        t_cluster_word w;
        if (op == OP_ADD) begin
            r2    = longint'(cfg_radius) * longint'(cfg_radius);
            hit_k = -1;
            // first filled entry strictly inside the radius wins
            for (k = 0; k < tab_used; k++) begin
                dx = longint'(tab_mean_x[k]) - longint'(px);
                dy = longint'(tab_mean_y[k]) - longint'(py);
                if (dx * dx + dy * dy < r2) begin
                    hit_k = k;
                    break;
                end
            end
            if (hit_k >= 0) begin
                // hold the count at its ceiling, but keep averaging with it
                if (tab_hits[hit_k] != HITS_MAX)
                    tab_hits[hit_k] = tab_hits[hit_k] + 1'b1;
                n = longint'(tab_hits[hit_k]);
                // signed division truncates toward zero, as the block must
                tab_mean_x[hit_k] = COORD_W'((longint'(tab_mean_x[hit_k]) * (n - 1)
                                             + longint'(px)) / n);
                tab_mean_y[hit_k] = COORD_W'((longint'(tab_mean_y[hit_k]) * (n - 1)
                                             + longint'(py)) / n);
                w = '{STS_MERGED, CINDEX_W'(hit_k), tab_mean_x[hit_k],
                      tab_mean_y[hit_k], tab_hits[hit_k], 1'b1};
            end else if (tab_used < TABLE_DEPTH) begin
                tab_mean_x[tab_used] = px;
                tab_mean_y[tab_used] = py;
                tab_hits[tab_used]   = 1;
                w = '{STS_NEW, CINDEX_W'(tab_used), px, py, HITS_W'(1), 1'b1};
                tab_used++;
            end else begin
                // table full: drop the point, all payload fields zero
                w = '{STS_DROPPED, '0, '0, '0, '0, 1'b1};
            end
            pending_words.push_back(w);
        end else begin
            last_k = -1;
            for (k = 0; k < tab_used; k++)
                if (tab_hits[k] > cfg_min_count)
                    last_k = k;
            if (last_k < 0) begin
                w = '{STS_NONE, '0, '0, '0, '0, 1'b1};
                pending_words.push_back(w);
            end else begin
                for (k = 0; k <= last_k; k++) begin
                    if (tab_hits[k] > cfg_min_count) begin
                        w = '{STS_REPORT, CINDEX_W'(k), tab_mean_x[k], tab_mean_y[k],
                              tab_hits[k], k == last_k};
                        pending_words.push_back(w);
                    end
                end
            end
            // only the fill level drops; stale entries are never visited again
            tab_used = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Input channel: hold valid and payload until the word is taken.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_point_x  <= x;
        i_point_y  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        cluster_predict(op, x, y);
    endtask

    // Drop valid and hold off until every owed result word has been checked.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port: setup phase, then access phase, then idle.
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want,
                            input string what);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            report_mismatch(what, want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write both registers, mirror them, and read them back.
    task automatic set_config(input logic [RADIUS_W-1:0] radius,
                              input logic [HITS_W-1:0] min_hits);
        reg_write(RADIUS_ADDR, DATA_W'(radius));
        reg_write(MIN_COUNT_ADDR, DATA_W'(min_hits));
        cfg_radius    = radius;
        cfg_min_count = min_hits;
        reg_read(RADIUS_ADDR, DATA_W'(radius), "match_radius read-back");
        reg_read(MIN_COUNT_ADDR, DATA_W'(min_hits), "min_count read-back");
    endtask

    // ------------------------------------------------------------------------
    // Point generation: mostly scatter around a few hubs, some full-range noise.
    // ------------------------------------------------------------------------
    task automatic new_hubs();
        int h;
        for (h = 0; h < NUM_HUBS; h++) begin
            hub_x[h] = COORD_W'($urandom);
            hub_y[h] = COORD_W'($urandom);
        end
    endtask

    task automatic pick_point(input int spread, output logic signed [COORD_W-1:0] x,
                              output logic signed [COORD_W-1:0] y);
        int h, vx, vy;
        if ($urandom_range(0, 3) == 0) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else begin
            h  = $urandom_range(0, NUM_HUBS - 1);
            vx = int'(hub_x[h]) + int'($urandom_range(0, 2 * spread)) - spread;
            vy = int'(hub_y[h]) + int'($urandom_range(0, 2 * spread)) - spread;
            // clamp to the coordinate range rather than wrap
            if (vx > 32767) vx = 32767; else if (vx < -32768) vx = -32768;
            if (vy > 32767) vy = 32767; else if (vy < -32768) vy = -32768;
            x = vx[COORD_W-1:0];
            y = vy[COORD_W-1:0];
        end
    endtask

    task automatic send_random(input int spread, input int flush_pct);
        logic signed [COORD_W-1:0] x, y;
        pick_point(spread, x, y);
        if ($urandom_range(0, 99) < flush_pct)
            send_word(OP_FLUSH, x, y);
        else
            send_word(OP_ADD, x, y);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_reset();
        reg_read(RADIUS_ADDR, DATA_W'(MATCH_RADIUS_RESET), "match_radius after reset");
        reg_read(MIN_COUNT_ADDR, DATA_W'(MIN_COUNT_RESET), "min_count after reset");
    endtask

    // Reset settings: radius 10, report above 5 hits.
    task automatic test_directed_points();
        send_word(OP_ADD, 0, 0);             // opens entry 0
        send_word(OP_ADD, 3, 4);             // merges, mean halves
        send_word(OP_ADD, 10, 0);            // still inside, mean truncates
        send_word(OP_ADD, 1000, 1000);       // new entry
        send_word(OP_ADD, 1010, 1000);       // exactly on the radius: new entry
        send_word(OP_ADD, 1000, 1009);       // inside only the entry at (1000, 1000): merges
        send_word(OP_ADD, 32767, 32767);     // corners of the coordinate range
        send_word(OP_ADD, -32768, -32768);
        send_word(OP_ADD, 32767, -32768);
        send_word(OP_ADD, -32768, 32767);
        send_word(OP_ADD, -32763, -32767);   // negative mean truncates toward zero
        send_word(OP_ADD, 32760, 32767);
        send_word(OP_FLUSH, -1, 0);          // nothing above min_count
        send_word(OP_ADD, -5, -5);
        send_word(OP_ADD, -6, -4);
        send_word(OP_ADD, -4, -7);
        send_word(OP_ADD, -3, -5);
        send_word(OP_ADD, -7, -6);
        send_word(OP_ADD, -5, -2);
        send_word(OP_ADD, -8, -5);
        send_word(OP_FLUSH, 0, -1);          // single report, last set
        send_word(OP_FLUSH, 12345, -12345);  // empty table
        wait_idle();
    endtask

    // Zero radius: nothing merges, not even a repeated point; overflow the
    // table, then report every entry in one flush.
    task automatic test_zero_radius_fill();
        int i;
        set_config('0, '0);
        new_hubs();
        send_word(OP_ADD, hub_x[0], hub_y[0]);
        send_word(OP_ADD, hub_x[0], hub_y[0]);
        for (i = 0; i < 66; i++)
            send_random(3, 0);
        send_word(OP_FLUSH, 0, 0);
        wait_idle();
    endtask

    // Widest radius and the highest threshold: flushes never report.
    task automatic test_wide_radius();
        int i;
        set_config({RADIUS_W{1'b1}}, {HITS_W{1'b1}});
        new_hubs();
        for (i = 0; i < 60; i++)
            send_random(1500, 4);
        send_word(OP_FLUSH, 0, 0);
        wait_idle();
    endtask

    // Random settings, with stretches of idling and occasional full drains.
    task automatic test_random_clusters();
        int i, spread;
        for (i = 0; i < 150; i++) begin
            if (i % 75 == 0) begin
                wait_idle();
                set_config(RADIUS_W'($urandom_range(1, 200)),
                           HITS_W'($urandom_range(0, 8)));
                new_hubs();
                spread = int'(cfg_radius) + 20;
            end
            idling = (i % 40) < 28;
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            send_random(spread, 6);
        end
        idling = 1'b1;
        wait_idle();
    endtask

    // Final stretch: no idling on either side, back-to-back words.
    task automatic test_steady_stream();
        int i;
        set_config(10'd50, 16'd2);
        new_hubs();
        idling = 1'b0;
        for (i = 0; i < 70; i++)
            send_random(70, 10);
        send_word(OP_FLUSH, 0, 0);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: stall in random bursts while idling is on.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_hold > 0)
            sink_hold = sink_hold - 1;
        else if (idling && $urandom_range(0, 4) == 0)
            sink_hold = $urandom_range(1, 5);
        i_out_ready <= (sink_hold == 0);
    end

    // Checker: compare each accepted result word with the oldest owed one.
    t_cluster_word want_w;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected result word, status", '0, o_status);
            end else begin
                want_w = pending_words.pop_front();
                if (want_w.status !== o_status)
                    report_mismatch("status", want_w.status, o_status);
                if (want_w.cindex !== o_cluster_index)
                    report_mismatch("cluster_index", want_w.cindex, o_cluster_index);
                if (want_w.mean_x !== o_mean_x)
                    report_mismatch("mean_x", want_w.mean_x, o_mean_x);
                if (want_w.mean_y !== o_mean_y)
                    report_mismatch("mean_y", want_w.mean_y, o_mean_y);
                if (want_w.hits !== o_hit_count)
                    report_mismatch("hit_count", want_w.hits, o_hit_count);
                if (want_w.last !== o_last)
                    report_mismatch("last", want_w.last, o_last);
            end
        end
    end

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_points();
        test_zero_radius_fill();
        test_wide_radius();
        test_random_clusters();
        test_steady_stream();
        wait_idle();
        // catch any stray result word after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
